>>> rtl/core/decimate_rotate_frame_defines.svh
// ----------------------------------------------------------------------------
// decimate_rotate_frame_defines
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
// Each macro checks on the rising edge of clk and is off while arst_n is low.
`ifndef DECIMATE_ROTATE_FRAME_DEFINES_SVH
`define DECIMATE_ROTATE_FRAME_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/drf_pkg.sv
// ----------------------------------------------------------------------------
// drf_pkg
// Types and constants for the decimate and rotate frame block.
// ----------------------------------------------------------------------------
package drf_pkg;

	localparam int DEF_MAX_SIDE = 64;
	localparam int CFG_W        = 7;
	localparam int PIX_W        = 16;
	localparam int LUMA_W       = 8;

	localparam logic [CFG_W-1:0]  CFG_SIDE_RESET = 7'd64;
	localparam logic [LUMA_W-1:0] LUMA_BIAS      = 8'd128;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_PULL = 1'b1
	} op_t;

endpackage

>>> rtl/core/decimate_rotate_frame.sv
// Result: a pull that finds the frame full shows its result in the cycle after acceptance.
// Throughput: one item per cycle, pushes and pulls alike, while no unread result stalls
// the input; the single frame memory takes one write (push) or one read (pull) per cycle.
// Reset: counters, frame-full flag and output valid clear at once; the side register
// returns to 64. The frame memory is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// decimate_rotate_frame
// Stores the luma of every even-row, even-column camera pixel in a frame memory
// and reads the decimated frame back rotated by 90 degrees, biased to signed.
// ----------------------------------------------------------------------------
`include "decimate_rotate_frame_defines.svh"

module decimate_rotate_frame
	import drf_pkg::*;
#(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [PIX_W-1:0]         camera_pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [LUMA_W-1:0] signed_luma,
	output logic                     frame_end,
	input  logic                     cfg_we,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int CW    = (SW > CFG_W) ? SW : CFG_W;
	localparam int IW    = $clog2(2 * MAX_SIDE);
	localparam int OW    = $clog2(MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	logic [CFG_W-1:0]  side_q;
	logic [IW-1:0]     in_row_q, in_col_q;
	logic              frame_full_q;
	logic [OW-1:0]     out_row_q, out_col_q;
	logic [AW-1:0]     col_off_q;
	logic [AW-1:0]     wr_addr_q;
	logic [LUMA_W-1:0] rd_data_q;
	logic              out_valid_q;
	logic              frame_end_q;

	logic [LUMA_W-1:0] luma_mem [DEPTH];

	logic [CW-1:0] side_ext;
	logic [SW-1:0] eff_side;
	logic [SW:0]   src_side;
	logic [IW-1:0] src_last;
	logic [OW-1:0] side_last;
	logic [OW-1:0] rd_base;
	logic [AW-1:0] rd_addr;
	logic          accept;
	logic          push_acc;
	logic          pull_acc;
	logic          do_store;
	logic          in_col_end;
	logic          in_row_end;
	logic          out_col_end;
	logic          out_last;

	// Clamp the side register to 1..MAX_SIDE.
	always_comb begin
		side_ext = CW'(side_q);
		if (side_ext == '0) begin
			eff_side = SW'(1);
		end else if (side_ext > CW'(MAX_SIDE)) begin
			eff_side = SW'(MAX_SIDE);
		end else begin
			eff_side = SW'(side_ext);
		end
	end

	assign src_side  = {eff_side, 1'b0};
	assign src_last  = IW'(src_side - (SW+1)'(1));
	assign side_last = OW'(eff_side - SW'(1));

	// Stall only when the result register is full and not being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign push_acc = accept && (op_t'(operation) == OP_PUSH) && !frame_full_q;
	assign pull_acc = accept && (op_t'(operation) == OP_PULL) && frame_full_q;

	assign do_store   = push_acc && !in_row_q[0] && !in_col_q[0];
	assign in_col_end = (in_col_q == src_last);
	assign in_row_end = (in_row_q == src_last);

	// Output (r,c) reads stored (c, side-1-r); col_off_q tracks c*side.
	assign rd_base     = side_last - out_row_q;
	assign rd_addr     = col_off_q + AW'(rd_base);
	assign out_col_end = (out_col_q == side_last);
	assign out_last    = out_col_end && (out_row_q == side_last);

	always_ff @(posedge clk) begin
		if (do_store) begin
			luma_mem[wr_addr_q] <= camera_pixel[LUMA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pull_acc) begin
			rd_data_q <= luma_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q       <= CFG_SIDE_RESET;
			in_row_q     <= '0;
			in_col_q     <= '0;
			frame_full_q <= 1'b0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			col_off_q    <= '0;
			wr_addr_q    <= '0;
		end else if (cfg_we) begin
			// Abandon the current frame; memory contents stay.
			side_q       <= cfg_data;
			in_row_q     <= '0;
			in_col_q     <= '0;
			frame_full_q <= 1'b0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			col_off_q    <= '0;
			wr_addr_q    <= '0;
		end else if (push_acc) begin
			if (do_store) begin
				wr_addr_q <= wr_addr_q + AW'(1);
			end
			if (in_col_end) begin
				in_col_q <= '0;
				if (in_row_end) begin
					in_row_q     <= '0;
					frame_full_q <= 1'b1;
				end else begin
					in_row_q <= in_row_q + IW'(1);
				end
			end else begin
				in_col_q <= in_col_q + IW'(1);
			end
		end else if (pull_acc) begin
			if (out_last) begin
				frame_full_q <= 1'b0;
				out_row_q    <= '0;
				out_col_q    <= '0;
				col_off_q    <= '0;
				wr_addr_q    <= '0;
			end else if (out_col_end) begin
				out_col_q <= '0;
				col_off_q <= '0;
				out_row_q <= out_row_q + OW'(1);
			end else begin
				out_col_q <= out_col_q + OW'(1);
				col_off_q <= col_off_q + AW'(eff_side);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pull_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pull_acc) begin
			frame_end_q <= out_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign signed_luma = rd_data_q - LUMA_BIAS;
	assign frame_end   = frame_end_q;

	`DRF_ASSERT_NEXT(a_pull_gives_item, pull_acc && !cfg_we, out_valid_q,
		"accepted pull on a full frame produced no item")
	`DRF_ASSERT_NEXT(a_early_pull_silent,
		accept && (op_t'(operation) == OP_PULL) && !frame_full_q, !out_valid_q,
		"pull before frame full produced an item")
	`DRF_ASSERT_SAME(a_end_restarts, out_valid_q && frame_end_q, !frame_full_q,
		"frame still full after its last item was read")
	`DRF_ASSERT_SAME(a_full_at_origin, frame_full_q,
		(in_row_q == '0) && (in_col_q == '0),
		"input position not at origin while frame full")
	`DRF_ASSERT_SAME(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready,
		"input taken while result is stalled")

endmodule
